### src/pee_pkg.sv
// shared types and constants of the postfix expression evaluator
`timescale 1ns / 1ps
package pee_pkg;

  localparam int VALUE_W    = 32;
  localparam int SYMBOL_W   = 8;
  localparam int STATUS_W   = 2;
  localparam int IMM_W      = SYMBOL_W + 1;
  localparam int OUT_DATA_W = 40;

  // expression characters
  localparam logic [SYMBOL_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] SYM_STAR  = 8'h2A;
  localparam logic [SYMBOL_W-1:0] SYM_SLASH = 8'h2F;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // one classified request passed from front to back
  typedef struct packed {
    op_t                    op;
    logic signed [IMM_W-1:0] imm;
    logic                   last;
  } item_t;

endpackage

### src/pee_front.sv
// front end: accepts characters, classifies them and queues them for the back end
`timescale 1ns / 1ps
module pee_front import pee_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SYMBOL_W-1:0] s_tdata,
  input  logic                s_tlast,
  output logic                q_valid,
  input  logic                q_ready,
  output item_t               q_item
);

  item_t       q_mem [2];
  logic        wp;
  logic        rp;
  logic [1:0]  fill;
  item_t       cls;
  logic        push;
  logic        pop;

  always_comb begin
    cls.last = s_tlast;
    cls.imm  = $signed({1'b0, s_tdata}) - $signed({1'b0, SYM_ZERO});
    unique case (s_tdata)
      SYM_PLUS:  cls.op = OP_ADD;
      SYM_MINUS: cls.op = OP_SUB;
      SYM_STAR:  cls.op = OP_MUL;
      SYM_SLASH: cls.op = OP_DIV;
      default:   cls.op = OP_PUSH;
    endcase
  end

  assign s_tready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = q_mem[rp];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

### src/pee_divider.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
module pee_divider import pee_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [VALUE_W-1:0] divisor,
  output logic               done,
  output logic [VALUE_W-1:0] quotient
);

  localparam int CW = $clog2(VALUE_W);

  logic               busy;
  logic [CW-1:0]      cnt;
  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] quo;
  logic [VALUE_W-1:0] dvs;
  logic               neg;
  logic [VALUE_W:0]   rem_sh;
  logic [VALUE_W:0]   diff;
  logic               na;
  logic               nb;

  assign na       = dividend[VALUE_W-1];
  assign nb       = divisor[VALUE_W-1];
  assign rem_sh   = {rem, quo[VALUE_W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = neg ? (~quo + VALUE_W'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= na ? (~dividend + VALUE_W'(1)) : dividend;
      dvs <= nb ? (~divisor + VALUE_W'(1)) : divisor;
      neg <= na ^ nb;
    end else if (busy) begin
      if (!diff[VALUE_W]) begin
        rem <= diff[VALUE_W-1:0];
        quo <= {quo[VALUE_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[VALUE_W-1:0];
        quo <= {quo[VALUE_W-2:0], 1'b0};
      end
    end
  end

endmodule

### src/pee_back.sv
// back end: value stack with cached top, arithmetic and result register
`timescale 1ns / 1ps
module pee_back import pee_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  item_t                 q_item,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [VALUE_W-1:0] stack_mem [STACK_DEPTH];
  logic [VALUE_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_en;

  logic [1:0]         state;
  logic [CNT_W-1:0]   count;
  logic [STATUS_W-1:0] err;
  logic [VALUE_W-1:0] top;
  logic [VALUE_W-1:0] right_op;
  op_t                op_r;
  logic               last_r;
  logic               two_r;

  logic [VALUE_W-1:0] left_op;
  logic [VALUE_W-1:0] imm_ext;
  logic [CNT_W-1:0]   count_after_op;
  logic               take;
  logic               out_free;
  logic               emit;
  logic               div_start;
  logic               div_done;
  logic [VALUE_W-1:0] div_q;

  function automatic logic [STATUS_W-1:0] flag(input logic [STATUS_W-1:0] cur,
                                               input logic [STATUS_W-1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  assign q_ready        = (state == S_IDLE);
  assign take           = q_valid && q_ready;
  assign out_free       = !m_tvalid || m_tready;
  assign emit           = (state == S_EMIT) && out_free;
  assign imm_ext        = VALUE_W'(q_item.imm);
  assign left_op        = two_r ? rd_data : '0;
  assign count_after_op = two_r ? (count - CNT_W'(1)) : CNT_W'(1);
  assign rd_addr        = IDX_W'(count - CNT_W'(2));
  assign wr_addr        = IDX_W'(count - CNT_W'(1));
  assign wr_en          = take && (q_item.op == OP_PUSH) && (count != '0)
                          && (count < CNT_W'(STACK_DEPTH));
  assign div_start      = (state == S_EXEC) && (op_r == OP_DIV) && (right_op != '0);

  // stack below the cached top
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= top;
    end
    rd_data <= stack_mem[rd_addr];
  end

  pee_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left_op),
    .divisor  (right_op),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      err      <= ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            op_r   <= q_item.op;
            last_r <= q_item.last;
            if (q_item.op == OP_PUSH) begin
              if (count < CNT_W'(STACK_DEPTH)) begin
                top   <= imm_ext;
                count <= count + CNT_W'(1);
              end else begin
                err <= flag(err, ST_OVERFLOW);
              end
              state <= q_item.last ? S_EMIT : S_IDLE;
            end else begin
              right_op <= (count != '0) ? top : '0;
              two_r    <= (count >= CNT_W'(2));
              if (count < CNT_W'(2)) begin
                err <= flag(err, ST_UNDERFLOW);
              end
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          unique case (op_r)
            OP_ADD: top <= left_op + right_op;
            OP_SUB: top <= left_op - right_op;
            OP_MUL: top <= VALUE_W'(left_op * right_op);
            default: begin
              if (right_op == '0) begin
                top <= '0;
                err <= flag(err, ST_DIVZERO);
              end
            end
          endcase
          if (div_start) begin
            state <= S_DIV;
          end else begin
            count <= count_after_op;
            state <= last_r ? S_EMIT : S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            top   <= div_q;
            count <= count_after_op;
            state <= last_r ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit) begin
            m_tdata  <= {(OUT_DATA_W - VALUE_W - STATUS_W)'(0),
                         (count == '0) ? flag(err, ST_UNDERFLOW) : err,
                         (count == '0) ? '0 : top};
            count    <= '0;
            err      <= ST_OK;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/postfix_expression_evaluator_top.sv
// top level of the postfix expression evaluator
`timescale 1ns / 1ps
// Evaluates a postfix expression sent one character per request on the slave
// side; the character marked with tlast closes the expression and yields one
// result request on the master side carrying the popped top value and the
// first error seen (ok, stack underflow, stack overflow, divide by zero),
// after which the stack and status are cleared. A front end classifies each
// character into a two-entry queue, so input keeps flowing while the back end
// works. In the back end an operand is taken in the idle state; +, - and *
// also pass through an execute state, as the operand below the cached top is
// read from the stack memory; / with a nonzero divisor then waits in a divide
// state for the iterative divider, which produces one quotient bit per cycle;
// a closing character passes through an emit state that loads the result
// register, waiting there while the previous result is not taken. The stack
// memory needs no clearing pass after reset: entries are only used once written.
module postfix_expression_evaluator_top import pee_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // expression characters in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SYMBOL_W-1:0]   s_tdata,   // [7:0] symbol
  input  logic                  s_tlast,   // last character of the expression
  // results out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] value, [33:32] status, rest zero
);

  // queue between front and back
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  pee_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // stack engine, arithmetic and result register
  pee_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### src/pee_checker.sv
// port-level checks of the postfix expression evaluator, bound to the top level
`timescale 1ns / 1ps
module pee_checker import pee_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // no result survives a reset
  a_rst_out : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // queue is empty after reset, so input is open
  a_rst_in : assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // a waiting result holds
  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // padding bits above status stay zero
  a_pad : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_DATA_W-1:VALUE_W+STATUS_W] == '0))
    else $error("nonzero padding in result");

endmodule

bind postfix_expression_evaluator_top pee_checker u_pee_checker (.*);
